// ----- sv/assert_macros.svh -----
// Assertion macros shared by the checker files of this block.
// No dependencies; include once per file by its bare name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define MBP_ASSERT_SAME(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define MBP_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed: next-cycle implication");

// Next-cycle implication that is checked through reset as well.
`define MBP_ASSERT_NEXT_ALWAYS(label, clk, pre, post) \
   label: assert property (@(posedge clk) (pre) |=> (post)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ----- sv/mbp_pkg.sv -----
// Shared types and constants of the MSB-first bit packer.
// No dependencies; used by the store, the top level and the checker.
package mbp_pkg;

   localparam int CAPACITY_BYTES_DEF = 4096;
   localparam int OP_W    = 2;
   localparam int VAL_W   = 32;
   localparam int CNT_W   = 6;
   localparam int IDX_W   = 12;
   localparam int BYTE_W  = 8;
   localparam int LEN_W   = 16;
   localparam int STAT_W  = 2;
   localparam int MAX_BITS = 32;
   localparam int ACC_W   = BYTE_W + VAL_W;
   localparam int REQ_W   = 56;
   localparam int RSP_W   = 24;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND = 2'd0,
      OP_READ   = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   typedef logic [STAT_W-1:0] status_type;
   localparam status_type ST_OK       = 2'd0;
   localparam status_type ST_OVERFLOW = 2'd1;
   localparam status_type ST_PAST_END = 2'd2;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WRITE,
      S_READ,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

endpackage

// ----- sv/msb_first_bit_packer.sv -----
// MSB-first bit packer: appends 0 to 32 bits per append item to a byte stream kept
// in a single-port store, reads back one byte per read item, and clears on a clear
// item. One item is in work at a time; the result sits in an output register so the
// next item is taken while it waits. An append writes the bytes it completes (0 to 4)
// to the store, one byte write per cycle; a read of a completed byte goes through the
// registered store read; every other item is answered from the stream state alone.
// Depends on mbp_pkg and mbp_store.
module msb_first_bit_packer
   import mbp_pkg::*;
#(
   parameter int CAPACITY_BYTES = CAPACITY_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [REQ_W-1:0]  req_tdata,  // value[31:0], bit_count[37:32], byte_index[49:38]
   input  logic [OP_W-1:0]   req_tuser,  // op[1:0]
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_W-1:0]  rsp_tdata,  // byte_data[7:0], length_bits[23:8]
   output logic [STAT_W-1:0] rsp_tuser   // status[1:0]
);

   localparam int ADDR_W = (CAPACITY_BYTES > 1) ? $clog2(CAPACITY_BYTES) : 1;
   localparam int CAP_BITS = CAPACITY_BYTES * BYTE_W;
   localparam int TB_W = $clog2(CAP_BITS + 1);
   localparam int LXW = (TB_W > LEN_W) ? TB_W : LEN_W;
   localparam int CW = (TB_W > IDX_W + 3) ? TB_W : IDX_W + 3;

   // Item fields
   op_type             req_op;
   logic [VAL_W-1:0]   req_value;
   logic [CNT_W-1:0]   req_bit_count;
   logic [IDX_W-1:0]   req_byte_index;

   assign req_op         = op_type'(req_tuser);
   assign req_value      = req_tdata[VAL_W-1:0];
   assign req_bit_count  = req_tdata[VAL_W+CNT_W-1:VAL_W];
   assign req_byte_index = req_tdata[VAL_W+CNT_W+IDX_W-1:VAL_W+CNT_W];

   state_type          state_ff, state_in;
   logic [TB_W-1:0]    total_ff, total_in;
   logic [BYTE_W-1:0]  partial_ff, partial_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [2:0]         nb_ff, nb_in;
   logic [2:0]         cnt_ff, cnt_in;
   logic [ADDR_W-1:0]  wptr_ff, wptr_in;
   logic [BYTE_W-1:0]  res_data_ff, res_data_in;
   logic [LEN_W-1:0]   res_len_ff, res_len_in;
   status_type         res_stat_ff, res_stat_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [LEN_W-1:0]   rsp_len_ff, rsp_len_in;
   status_type         rsp_stat_ff, rsp_stat_in;

   mem_ctl_type        mem_ctl;
   logic [ADDR_W-1:0]  mem_addr;
   logic [BYTE_W-1:0]  mem_wdata;
   logic [BYTE_W-1:0]  mem_rdata;

   // Append datapath
   logic [CNT_W-1:0]   n_sat;
   logic [MAX_BITS:0]  mask;
   logic [VAL_W-1:0]   vmask;
   logic [2:0]         fill;
   logic [CNT_W-1:0]   fill_plus;
   logic [CNT_W-1:0]   sh;
   logic [ACC_W-1:0]   app_acc;
   logic [ACC_W-1:0]   app_acc_sh;
   logic [2:0]         app_nb;
   logic [TB_W:0]      app_sum;
   logic               app_over;
   logic [TB_W-1:0]    app_total;
   logic [LXW-1:0]     len_cur_x, len_app_x;

   // Read datapath
   logic [CW-1:0]      rd_bit;
   logic [CW-1:0]      total_x;
   logic [CW-1:0]      index_x;
   logic [CW-1:0]      cur_byte_x;
   logic               past_end;
   logic               at_partial;

   assign n_sat     = (req_bit_count > CNT_W'(MAX_BITS)) ? CNT_W'(MAX_BITS) : req_bit_count;
   assign mask      = ~({(MAX_BITS+1){1'b1}} << n_sat);
   assign vmask     = req_value & mask[VAL_W-1:0];
   assign fill      = total_ff[2:0];
   assign fill_plus = CNT_W'(fill) + n_sat;
   assign sh        = CNT_W'(ACC_W) - CNT_W'(fill) - n_sat;
   assign app_acc   = {partial_ff, {VAL_W{1'b0}}} | (ACC_W'(vmask) << sh);
   assign app_nb    = fill_plus[CNT_W-1:3];
   assign app_acc_sh = app_acc << {app_nb, 3'b000};
   assign app_sum   = (TB_W+1)'(total_ff) + (TB_W+1)'(n_sat);
   assign app_over  = app_sum > (TB_W+1)'(CAP_BITS);
   assign app_total = app_sum[TB_W-1:0];
   assign len_cur_x = LXW'(total_ff);
   assign len_app_x = LXW'(app_total);

   assign rd_bit     = CW'({req_byte_index, 3'b000});
   assign total_x    = CW'(total_ff);
   assign index_x    = CW'(req_byte_index);
   assign cur_byte_x = CW'(total_ff[TB_W-1:3]);
   assign past_end   = rd_bit >= total_x;
   assign at_partial = index_x == cur_byte_x;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      total_in     = total_ff;
      partial_in   = partial_ff;
      acc_in       = acc_ff;
      nb_in        = nb_ff;
      cnt_in       = cnt_ff;
      wptr_in      = wptr_ff;
      res_data_in  = res_data_ff;
      res_len_in   = res_len_ff;
      res_stat_in  = res_stat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_stat_in  = rsp_stat_ff;
      mem_ctl      = '0;
      mem_addr     = wptr_ff;
      mem_wdata    = acc_ff[ACC_W-1 -: BYTE_W];
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               res_data_in = '0;
               res_stat_in = ST_OK;
               res_len_in  = len_cur_x[LEN_W-1:0];
               state_in    = S_FINISH;
               unique case (req_op)
                  OP_APPEND: begin
                     if (app_over) begin
                        res_stat_in = ST_OVERFLOW;
                     end else begin
                        total_in   = app_total;
                        partial_in = app_acc_sh[ACC_W-1 -: BYTE_W];
                        res_len_in = len_app_x[LEN_W-1:0];
                        acc_in     = app_acc;
                        nb_in      = app_nb;
                        cnt_in     = '0;
                        wptr_in    = ADDR_W'(total_ff[TB_W-1:3]);
                        if (app_nb != 3'd0) begin
                           state_in = S_WRITE;
                        end
                     end
                  end
                  OP_READ: begin
                     if (past_end) begin
                        res_stat_in = ST_PAST_END;
                     end else if (at_partial) begin
                        res_data_in = partial_ff;
                     end else begin
                        mem_ctl.rd_en = 1'b1;
                        mem_addr      = ADDR_W'(req_byte_index);
                        state_in      = S_READ;
                     end
                  end
                  OP_CLEAR: begin
                     total_in   = '0;
                     partial_in = '0;
                     res_len_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_WRITE: begin
            // emit one completed byte per cycle, oldest first
            mem_ctl.wr_en = 1'b1;
            acc_in  = acc_ff << BYTE_W;
            wptr_in = wptr_ff + ADDR_W'(1);
            cnt_in  = cnt_ff + 3'd1;
            if (cnt_ff + 3'd1 == nb_ff) begin
               state_in = S_FINISH;
            end
         end
         S_READ: begin
            res_data_in = mem_rdata;
            state_in    = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_data_ff;
               rsp_len_in   = res_len_ff;
               rsp_stat_in  = res_stat_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         total_ff     <= '0;
         partial_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         partial_ff   <= partial_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      nb_ff       <= nb_in;
      cnt_ff      <= cnt_in;
      wptr_ff     <= wptr_in;
      res_data_ff <= res_data_in;
      res_len_ff  <= res_len_in;
      res_stat_ff <= res_stat_in;
      rsp_data_ff <= rsp_data_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   mbp_store #(
      .DEPTH  (CAPACITY_BYTES),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock (clock),
      .ctl   (mem_ctl),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_len_ff, rsp_data_ff};
   assign rsp_tuser  = rsp_stat_ff;

endmodule

// ----- sv/mbp_store.sv -----
// Single-port byte store with a registered read, one access per cycle.
// Depends on mbp_pkg for the port control struct.
module mbp_store
   import mbp_pkg::*;
#(
   parameter int DEPTH  = CAPACITY_BYTES_DEF,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  mem_ctl_type       ctl,
   input  logic [ADDR_W-1:0] addr,
   input  logic [BYTE_W-1:0] wdata,
   output logic [BYTE_W-1:0] rdata
);

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[addr] <= wdata;
      end
      if (ctl.rd_en) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- sv/mbp_checker.sv -----
// Port-level checks for the MSB-first bit packer, bound to the top level.
// Depends on mbp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mbp_checker
   import mbp_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [RSP_W-1:0]  rsp_tdata,
   input logic [STAT_W-1:0] rsp_tuser
);

   logic                     rsp_fail;
   logic                     rsp_stall;
   logic                     status_known;
   logic [RSP_W+STAT_W-1:0]  rsp_word;

   assign rsp_fail     = rsp_tvalid && (rsp_tuser != ST_OK);
   assign rsp_stall    = rsp_tvalid && !rsp_tready;
   assign status_known = (rsp_tuser == ST_OK) || (rsp_tuser == ST_OVERFLOW)
                         || (rsp_tuser == ST_PAST_END);
   assign rsp_word     = {rsp_tuser, rsp_tdata};

   // a failing item carries no byte
   `MBP_ASSERT_SAME(a_err_no_data, clock, reset, rsp_fail, rsp_tdata[BYTE_W-1:0] == '0)

   `MBP_ASSERT_SAME(a_status_code, clock, reset, rsp_tvalid, status_known)

   `MBP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_word))

   // one item in work: no second item right after an accept
   `MBP_ASSERT_NEXT(a_one_item, clock, reset, req_tvalid && req_tready, !req_tready)

   `MBP_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_tvalid)

endmodule

bind msb_first_bit_packer mbp_checker u_mbp_checker (.*);

// ----- verif/tb_msb_first_bit_packer.sv -----
// Self-checking testbench for msb_first_bit_packer: directed, random and fill-to-capacity items.
// It predicts each result from a local copy of the bit stream and compares it field by field.
// Depends on mbp_pkg and the packer RTL.
module tb_msb_first_bit_packer
   import mbp_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAP_BITS       = CAPACITY_BYTES_DEF * 8;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 16;
   localparam int REPORT_LIMIT   = 10;

   typedef struct packed {
      logic [BYTE_W-1:0] byte_data;
      logic [LEN_W-1:0]  length_bits;
      status_type        status;
   } stream_answer_type;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata  = '0;   // value[31:0], bit_count[37:32], byte_index[49:38]
   logic [OP_W-1:0]   req_tuser  = '0;   // op[1:0]
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;         // byte_data[7:0], length_bits[23:8]
   logic [STAT_W-1:0] rsp_tuser;         // status[1:0]

   // mirror of the stream held by the block
   logic [BYTE_W-1:0] mirror_bytes [CAPACITY_BYTES_DEF];
   logic [BYTE_W-1:0] mirror_partial = '0;
   int unsigned       mirror_bits    = 0;

   stream_answer_type pending_answers [$];
   int unsigned    error_count = 0;
   int unsigned    quiet_cycles = 0;
   int unsigned    stall_left = 0;
   bit             idle_enable = 1'b1;

   msb_first_bit_packer #(
      .CAPACITY_BYTES(CAPACITY_BYTES_DEF)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (!idle_enable || roll < 60) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Advance the mirror by one item and return the result it must produce.
   function automatic stream_answer_type apply_stream_op(op_type op, logic [VAL_W-1:0] value,
                                                         logic [CNT_W-1:0] count,
                                                         logic [IDX_W-1:0] index);
      stream_answer_type answer;
      int unsigned    nbits;
      int unsigned    byte_pos;
      answer   = '0;
      nbits    = (count > CNT_W'(MAX_BITS)) ? MAX_BITS : 32'(count);
      byte_pos = 32'(index);
      case (op)
         OP_APPEND: begin
            if (mirror_bits + nbits > CAP_BITS) begin
               answer.status = ST_OVERFLOW;
            end else begin
               for (int i = nbits - 1; i >= 0; i--) begin
                  mirror_partial[7 - (mirror_bits % 8)] = value[i];
                  mirror_bits++;
                  if (mirror_bits % 8 == 0) begin
                     mirror_bytes[mirror_bits / 8 - 1] = mirror_partial;
                     mirror_partial = '0;
                  end
               end
            end
         end
         OP_READ: begin
            if (byte_pos * 8 >= mirror_bits) answer.status = ST_PAST_END;
            else if (byte_pos == mirror_bits / 8) answer.byte_data = mirror_partial;
            else answer.byte_data = mirror_bytes[byte_pos];
         end
         OP_CLEAR: begin
            mirror_bits    = 0;
            mirror_partial = '0;
         end
         default: ;
      endcase
      answer.length_bits = mirror_bits[LEN_W-1:0];
      return answer;
   endfunction

   task automatic report_error(string msg);
      error_count++;
      if (error_count <= REPORT_LIMIT) $display("%s", msg);
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want)
         report_error($sformatf("mismatch on %s: expected %0d, got %0d", name, want, got));
   endtask

   task automatic send_item(op_type op, logic [VAL_W-1:0] value, logic [CNT_W-1:0] count,
                            logic [IDX_W-1:0] index);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(REQ_W - IDX_W - CNT_W - VAL_W){1'b0}}, index, count, value};
      do @(posedge clock); while (!req_tready);
      pending_answers.push_back(apply_stream_op(op, value, count, index));
   endtask

   // Hold the sender until every outstanding result has come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_answers.size() != 0);
   endtask

   task automatic send_random_item();
      int unsigned      roll;
      op_type           op;
      logic [CNT_W-1:0] count;
      logic [IDX_W-1:0] index;
      roll = $urandom_range(0, 99);
      if (roll < 55) op = OP_APPEND;
      else if (roll < 88) op = OP_READ;
      else if (roll < 94) op = OP_NOP;
      else op = OP_CLEAR;
      count = ($urandom_range(0, 3) == 0) ? CNT_W'($urandom_range(0, 63))
                                          : CNT_W'($urandom_range(0, 16));
      if ($urandom_range(0, 1)) index = IDX_W'($urandom_range(0, mirror_bits / 8 + 1));
      else index = IDX_W'($urandom());
      send_item(op, $urandom(), count, index);
   endtask

   task automatic test_directed_cases();
      idle_enable = 1'b1;
      send_item(OP_READ, 32'h0, 6'd0, 12'd0);            // read of an empty stream
      send_item(OP_NOP, 32'h0, 6'd0, 12'd0);
      send_item(OP_APPEND, 32'hFFFF_FFFF, 6'd0, 12'd0);  // zero-bit append
      send_item(OP_APPEND, 32'h1, 6'd1, 12'd0);
      send_item(OP_READ, 32'h0, 6'd0, 12'd0);            // partial byte
      send_item(OP_APPEND, 32'h55, 6'd7, 12'd0);
      send_item(OP_READ, 32'h0, 6'd0, 12'd0);
      send_item(OP_READ, 32'h0, 6'd0, 12'd1);
      send_item(OP_APPEND, 32'hFFFF_FFFF, 6'd32, 12'd0);
      send_item(OP_APPEND, 32'h0, 6'd63, 12'd0);         // counts above 32 saturate
      send_item(OP_APPEND, 32'hA5A5_A5A5, 6'd33, 12'd0);
      send_item(OP_APPEND, 32'h1F, 6'd5, 12'd0);
      send_item(OP_READ, 32'h0, 6'd0, 12'd1);
      send_item(OP_READ, 32'h0, 6'd0, 12'd9);
      send_item(OP_READ, 32'h0, 6'd0, 12'd13);
      send_item(OP_READ, 32'h0, 6'd0, 12'd14);
      send_item(OP_READ, 32'h0, 6'd0, 12'd4095);
      drain_results();
      send_item(OP_CLEAR, 32'hFFFF_FFFF, 6'd63, 12'd4095);
      send_item(OP_READ, 32'h0, 6'd0, 12'd0);
      send_item(OP_APPEND, 32'h5, 6'd3, 12'd0);
      send_item(OP_READ, 32'h0, 6'd0, 12'd0);
      send_item(OP_NOP, 32'hFFFF_FFFF, 6'd63, 12'd4095);
      send_item(OP_APPEND, 32'h8000_0001, 6'd32, 12'd0);
   endtask

   task automatic test_random_mix();
      idle_enable = 1'b0;
      repeat (50) send_random_item();
      idle_enable = 1'b1;
      repeat (100) send_random_item();
   endtask

   task automatic test_fill_to_capacity();
      int unsigned room;
      send_item(OP_CLEAR, $urandom(), CNT_W'($urandom()), IDX_W'($urandom()));
      while (mirror_bits + MAX_BITS <= CAP_BITS) begin
         if ($urandom_range(0, 99) < 90)
            send_item(OP_APPEND, $urandom(), CNT_W'($urandom_range(20, 63)),
                      IDX_W'($urandom()));
         else
            send_item(OP_READ, $urandom(), CNT_W'($urandom()),
                      IDX_W'($urandom_range(0, mirror_bits / 8)));
      end
      send_item(OP_APPEND, $urandom(), 6'd32, IDX_W'($urandom()));  // rejected, too little room
      room = CAP_BITS - mirror_bits;
      send_item(OP_APPEND, $urandom(), CNT_W'(room), IDX_W'($urandom()));
      send_item(OP_APPEND, 32'hFFFF_FFFF, 6'd1, 12'd0);      // rejected at full
      send_item(OP_APPEND, $urandom(), 6'd0, 12'd0);
      send_item(OP_READ, 32'h0, 6'd0, 12'd4095);
      send_item(OP_READ, 32'h0, 6'd0, 12'd4094);
      send_item(OP_READ, 32'h0, 6'd0, IDX_W'($urandom()));
      send_item(OP_NOP, $urandom(), CNT_W'($urandom()), IDX_W'($urandom()));
      send_item(OP_CLEAR, $urandom(), CNT_W'($urandom()), IDX_W'($urandom()));
      send_item(OP_READ, 32'h0, 6'd0, 12'd4095);
      send_item(OP_APPEND, $urandom(), 6'd8, 12'd0);
      send_item(OP_READ, 32'h0, 6'd0, 12'd0);
   endtask

   // receiver: stall for random stretches
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         stall_left <= pick_gap();
      end
   end

   always @(posedge clock) begin : check_results
      stream_answer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_answers.size() == 0) begin
            report_error($sformatf("unexpected result: data %0d length %0d status %0d",
                                   rsp_tdata[7:0], rsp_tdata[23:8], rsp_tuser));
         end else begin
            want = pending_answers.pop_front();
            check_field("byte_data", 32'(want.byte_data), 32'(rsp_tdata[7:0]));
            check_field("length_bits", 32'(want.length_bits), 32'(rsp_tdata[23:8]));
            check_field("status", 32'(want.status), 32'(rsp_tuser));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d results outstanding", pending_answers.size());
         $display("msb_first_bit_packer regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_random_mix();
      test_fill_to_capacity();
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_answers.size() == 0) begin
         $display("msb_first_bit_packer regression: pass");
      end else begin
         $display("msb_first_bit_packer regression: fail");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/mbp_pkg.sv
sv/mbp_store.sv
sv/msb_first_bit_packer.sv
sv/mbp_checker.sv
verif/tb_msb_first_bit_packer.sv
